@@ sv/snst_pkg.sv @@
// shared types, constants and helpers of the sounding-note slot table
package snst_pkg;

  localparam int SLOTS  = 16;
  localparam int PARTS  = 16;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TICK_W = 40;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_FLUSH   = 2'd2
  } action_t;

  typedef enum logic {
    KIND_ON  = 1'b0,
    KIND_OFF = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [8:0] clip;
    logic       post_fx;
    logic [6:0] note;
    logic [4:0] channel;
    logic [5:0] part;
  } voice_t;

  typedef struct packed {
    logic [1:0]        action;
    voice_t            voice;
    logic [6:0]        velocity;
    logic [TICK_W-1:0] release_time;
    logic [11:0]       sample_offset;
    logic [TICK_W-1:0] block_start;
    logic [TICK_W-1:0] block_end;
  } item_t;

  typedef struct packed {
    logic              active;
    voice_t            voice;
    logic [TICK_W-1:0] rel;
  } entry_t;

  typedef struct packed {
    kind_t             kind;
    logic [5:0]        part;
    logic              post_fx;
    logic [4:0]        channel;
    logic [6:0]        note;
    logic [6:0]        velocity;
    logic [11:0]       offset;
    logic [TICK_W-1:0] tick;
  } msg_t;

  typedef struct packed {
    logic gen;
    logic clear;
    msg_t msg;
  } eval_t;

  // true when the part number addresses an existing part
  function automatic logic part_ok(input logic [5:0] p);
    return {1'b0, p} < 7'(PARTS);
  endfunction

endpackage

@@ sv/snst_slot_store.sv @@
// slot table storage: active flags, voices and release ticks
module snst_slot_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [snst_pkg::IDX_W-1:0] rd_idx,
  input  logic                       clr_en,
  input  logic                       wr_en,
  input  logic [snst_pkg::IDX_W-1:0] wr_idx,
  input  snst_pkg::voice_t           wr_voice,
  input  logic [snst_pkg::TICK_W-1:0] wr_rel,
  output snst_pkg::entry_t           entry
);

  logic                        active [snst_pkg::SLOTS];
  snst_pkg::voice_t            voice_mem [snst_pkg::SLOTS];
  logic [snst_pkg::TICK_W-1:0] rel_mem [snst_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < snst_pkg::SLOTS; i++) begin
        active[i] <= 1'b0;
      end
    end else begin
      if (clr_en) begin
        active[rd_idx] <= 1'b0;
      end
      if (wr_en) begin
        active[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      voice_mem[wr_idx] <= wr_voice;
      rel_mem[wr_idx]   <= wr_rel;
    end
  end

  assign entry.active = active[rd_idx];
  assign entry.voice  = voice_mem[rd_idx];
  assign entry.rel    = rel_mem[rd_idx];

endmodule

@@ sv/snst_slot_eval.sv @@
// shared slot check: match, due-time compare, clamp and message build
module snst_slot_eval (
  input  snst_pkg::item_t  item,
  input  snst_pkg::entry_t entry,
  output snst_pkg::eval_t  res
);

  logic hit;
  logic due;
  logic early;

  assign hit = entry.active
            && entry.voice.part    == item.voice.part
            && entry.voice.channel == item.voice.channel
            && entry.voice.note    == item.voice.note
            && entry.voice.post_fx == item.voice.post_fx;
  assign due   = entry.rel < item.block_end;
  assign early = entry.rel < item.block_start;

  always_comb begin
    res.gen          = 1'b0;
    res.clear        = 1'b0;
    res.msg.kind     = snst_pkg::KIND_OFF;
    res.msg.part     = entry.voice.part;
    res.msg.post_fx  = entry.voice.post_fx;
    res.msg.channel  = entry.voice.channel;
    res.msg.note     = entry.voice.note;
    res.msg.velocity = '0;
    res.msg.offset   = item.sample_offset;
    res.msg.tick     = '0;
    unique case (item.action)
      snst_pkg::ACT_START: begin
        res.clear = hit;
        res.gen   = hit;
      end
      snst_pkg::ACT_RELEASE: begin
        res.clear      = entry.active && due;
        res.gen        = entry.active && due && snst_pkg::part_ok(entry.voice.part);
        res.msg.offset = '0;
        res.msg.tick   = early ? item.block_start : entry.rel;
      end
      snst_pkg::ACT_FLUSH: begin
        res.clear = entry.active && (item.voice.clip[8] || entry.voice.clip == item.voice.clip);
        res.gen   = res.clear && snst_pkg::part_ok(entry.voice.part);
      end
      default: begin
        res.clear = 1'b0;
      end
    endcase
  end

endmodule

@@ sv/sounding_note_slot_table_top.sv @@
// sounding-note slot table: sequencer, message hold stage and output register
// sequence: one slot checked per cycle over all SLOTS (16) unless a message waits on a full output
//   register, then a place step for a start, then a closing drain step that sends the held message as the last
// a new item is taken only in idle, after the previous item has left the drain step; an unused
//   action or a start on a missing part gives no message and the sequencer stays idle
// a single table check unit serves every slot in turn
// reset: rst (synchronous) clears every slot's active flag and both valid stages
module sounding_note_slot_table_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  action,
  input  logic [5:0]                  part,
  input  logic signed [8:0]           clip,
  input  logic [4:0]                  channel,
  input  logic [6:0]                  note_number,
  input  logic [6:0]                  velocity,
  input  logic [snst_pkg::TICK_W-1:0] release_time,
  input  logic [11:0]                 sample_offset,
  input  logic                        post_fx,
  input  logic [snst_pkg::TICK_W-1:0] block_start,
  input  logic [snst_pkg::TICK_W-1:0] block_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        message_kind,
  output logic [5:0]                  out_part,
  output logic                        out_post_fx,
  output logic [4:0]                  out_channel,
  output logic [6:0]                  out_note,
  output logic [6:0]                  out_velocity,
  output logic [11:0]                 out_offset,
  output logic [snst_pkg::TICK_W-1:0] out_time,
  output logic                        last
);

  localparam logic [snst_pkg::IDX_W-1:0] LastIdx = snst_pkg::IDX_W'(snst_pkg::SLOTS - 1);

  snst_pkg::state_t            state, state_next;
  snst_pkg::item_t             item, item_next;
  logic [snst_pkg::IDX_W-1:0]  idx, idx_next;
  logic [snst_pkg::IDX_W-1:0]  free_idx, free_idx_next;
  logic                        found_free, found_free_next;
  logic                        hold_valid, hold_valid_next;
  snst_pkg::msg_t              hold_msg, hold_msg_next;
  logic                        out_valid_next;
  snst_pkg::msg_t              out_msg, out_msg_next;
  logic                        out_last, out_last_next;

  logic                        push;
  logic                        push_last;
  logic                        can_push;
  logic                        clr_en;
  logic                        wr_en;
  snst_pkg::entry_t            entry;
  snst_pkg::eval_t             ev;
  snst_pkg::msg_t              on_msg;

  snst_slot_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .clr_en   (clr_en),
    .wr_en    (wr_en),
    .wr_idx   (free_idx),
    .wr_voice (item.voice),
    .wr_rel   (item.release_time),
    .entry    (entry)
  );

  // one slot checked per scan cycle, unless a second message meets a full output register
  snst_slot_eval u_eval (
    .item  (item),
    .entry (entry),
    .res   (ev)
  );

  // note-on for the placed note
  always_comb begin
    on_msg.kind     = snst_pkg::KIND_ON;
    on_msg.part     = item.voice.part;
    on_msg.post_fx  = item.voice.post_fx;
    on_msg.channel  = item.voice.channel;
    on_msg.note     = item.voice.note;
    on_msg.velocity = item.velocity;
    on_msg.offset   = item.sample_offset;
    on_msg.tick     = '0;
  end

  // the hold stage keeps the newest message until we know whether it is the last
  assign can_push = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    item_next       = item;
    idx_next        = idx;
    free_idx_next   = free_idx;
    found_free_next = found_free;
    hold_valid_next = hold_valid;
    hold_msg_next   = hold_msg;
    push            = 1'b0;
    push_last       = 1'b0;
    clr_en          = 1'b0;
    wr_en           = 1'b0;
    in_ready        = 1'b0;
    unique case (state)
      snst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_next.action        = action;
          item_next.voice.clip    = clip;
          item_next.voice.post_fx = post_fx;
          item_next.voice.note    = note_number;
          item_next.voice.channel = channel;
          item_next.voice.part    = part;
          item_next.velocity      = velocity;
          item_next.release_time  = release_time;
          item_next.sample_offset = sample_offset;
          item_next.block_start   = block_start;
          item_next.block_end     = block_end;
          idx_next        = '0;
          found_free_next = 1'b0;
          hold_valid_next = 1'b0;
          // start on a missing part and the unused action give nothing
          if ((action == snst_pkg::ACT_START && snst_pkg::part_ok(part))
              || action == snst_pkg::ACT_RELEASE || action == snst_pkg::ACT_FLUSH) begin
            state_next = snst_pkg::ST_SCAN;
          end
        end
      end
      snst_pkg::ST_SCAN: begin
        // wait only when a second message meets a full output register
        if (!(ev.gen && hold_valid && !can_push)) begin
          clr_en = ev.clear;
          if (ev.gen) begin
            push            = hold_valid;
            hold_msg_next   = ev.msg;
            hold_valid_next = 1'b1;
          end
          // lowest slot free once the retrigger check is done
          if (item.action == snst_pkg::ACT_START && !found_free
              && (!entry.active || ev.clear)) begin
            found_free_next = 1'b1;
            free_idx_next   = idx;
          end
          if (idx == LastIdx) begin
            state_next = (item.action == snst_pkg::ACT_START) ? snst_pkg::ST_PLACE
                                                             : snst_pkg::ST_DRAIN;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      snst_pkg::ST_PLACE: begin
        if (!found_free) begin
          // table full: note dropped
          state_next = snst_pkg::ST_DRAIN;
        end else if (!(hold_valid && !can_push)) begin
          push            = hold_valid;
          hold_msg_next   = on_msg;
          hold_valid_next = 1'b1;
          wr_en           = 1'b1;
          state_next      = snst_pkg::ST_DRAIN;
        end
      end
      snst_pkg::ST_DRAIN: begin
        if (!hold_valid) begin
          state_next = snst_pkg::ST_IDLE;
        end else if (can_push) begin
          push            = 1'b1;
          push_last       = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = snst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = snst_pkg::ST_IDLE;
      end
    endcase
  end

  // output register, refilled as soon as the current transfer completes
  always_comb begin
    out_valid_next = out_valid;
    out_msg_next   = out_msg;
    out_last_next  = out_last;
    if (push) begin
      out_valid_next = 1'b1;
      out_msg_next   = hold_msg;
      out_last_next  = push_last;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= snst_pkg::ST_IDLE;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      found_free <= 1'b0;
      idx        <= '0;
    end else begin
      state      <= state_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      found_free <= found_free_next;
      idx        <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    free_idx <= free_idx_next;
    hold_msg <= hold_msg_next;
    out_msg  <= out_msg_next;
    out_last <= out_last_next;
  end

  assign message_kind = out_msg.kind;
  assign out_part     = out_msg.part;
  assign out_post_fx  = out_msg.post_fx;
  assign out_channel  = out_msg.channel;
  assign out_note     = out_msg.note;
  assign out_velocity = out_msg.velocity;
  assign out_offset   = out_msg.offset;
  assign out_time     = out_msg.tick;
  assign last         = out_last;

  // nothing is held over between items
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == snst_pkg::ST_IDLE |-> !hold_valid)
    else $error("held message left in idle");

  // a message never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // only a start item places a note
  a_place_start: assert property (@(posedge clk) disable iff (rst)
    state == snst_pkg::ST_PLACE |-> item.action == snst_pkg::ACT_START)
    else $error("place step on a non-start item");

  // a final message leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (push && push_last) |=> state == snst_pkg::ST_IDLE && out_valid && last)
    else $error("final message without return to idle");

endmodule
